// ----- rtl/dwsc_pkg.sv -----
// Shared types, widths and constants of the differential wheel speed controller.
package dwsc_pkg;

   localparam int DUTY_FULL_SCALE = 1000;

   localparam int DEV_W        = 16;
   localparam int PULSE_W      = 16;
   localparam int BASE_SPEED_W = 15;
   localparam int DIFFER_W     = 12;
   localparam int KP_W         = 8;
   localparam int DUTY_W       = 10;
   localparam int CSR_DATA_W   = 15;

   localparam int DIV_W   = 16;
   localparam int MAG_W   = 17;
   localparam int QUO_W   = BASE_SPEED_W;
   localparam int DVD_W   = QUO_W + DIV_W;
   localparam int SCALE_W = 13;
   localparam int PROD_W  = MAG_W + SCALE_W;
   localparam int SPEED_W = 21;
   localparam int ERR_W   = 22;
   localparam int GAIN_W  = 20;
   localparam int OFS_W   = 22;
   localparam int TG_W    = BASE_SPEED_W + GAIN_W;
   localparam int PE_W    = 31;
   localparam int ACC_W   = 48;
   localparam int FRAC_W  = 24;
   localparam int DRV_W   = ACC_W - FRAC_W;
   localparam int LANES   = 2;

   localparam logic [SCALE_W-1:0] PULSE_SCALE = 13'd5350;
   localparam logic [GAIN_W-1:0]  FF_GAIN_L   = 20'd611470;
   localparam logic [GAIN_W-1:0]  FF_GAIN_R   = 20'd568231;
   localparam logic [OFS_W-1:0]   FF_OFS_L    = 22'd3096614;
   localparam logic [OFS_W-1:0]   FF_OFS_R    = 22'd3938979;

   typedef enum logic [1:0] {
      CSR_BASE_SPEED = 2'd0,
      CSR_DIFFER     = 2'd1,
      CSR_KP         = 2'd2,
      CSR_MAX_DUTY   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BASE_SPEED_W-1:0] base_speed;
      logic [DIV_W-1:0]        div;
      logic [KP_W-1:0]         kp;
      logic [DUTY_W-1:0]       limit;
   } cfg_type;

   typedef struct packed {
      logic                          dev_neg;
      logic                          mag_zero;
      logic                          inner_zero;
      logic [LANES-1:0][SPEED_W-1:0] speed;
   } side_type;

endpackage

// ----- rtl/differential_wheel_speed_control.sv -----
// Top level of the differential-drive wheel speed controller.
// One transaction per clock is accepted when the result side does not stall, and one
// result per transaction leaves after three front stages (encoder scaling, operand
// products), fifteen divider stages that resolve one quotient bit each for the
// inner-wheel slowdown, and five drive stages (targets, products, sum, truncation, clamp
// and duty split). Every stage holds its transaction when the next one is full, so bubbles
// close up and a stall loses nothing. Configuration writes take effect on the next cycle.
// The user must make them while no transaction is in flight; the block does not enforce it.
module differential_wheel_speed_control (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // steer_deviation[15:0], left_pulses[31:16], right_pulses[47:32]
   input  logic [47:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // left_fwd_duty[9:0], left_rev_duty[19:10], right_fwd_duty[29:20], right_rev_duty[39:30]
   output logic [39:0]                     rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  dwsc_pkg::csr_index_type         csr_index,
   input  logic [dwsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dwsc_pkg::*;

   cfg_type          cfg;
   logic             fr_valid, fr_ready;
   logic [DVD_W-1:0] fr_dividend;
   side_type         fr_side;
   logic             dv_valid, dv_ready;
   logic [QUO_W-1:0] dv_quotient;
   side_type         dv_side;
   logic [DUTY_W-1:0] lf, lr, rf, rr;

   dwsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dwsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .steer_deviation (req_tdata[15:0]),
      .left_pulses     (req_tdata[31:16]),
      .right_pulses    (req_tdata[47:32]),
      .out_valid       (fr_valid),
      .out_ready       (fr_ready),
      .dividend        (fr_dividend),
      .side            (fr_side)
   );

   dwsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .divisor   (cfg.div),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .dividend  (fr_dividend),
      .side_in   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .quotient  (dv_quotient),
      .side_out  (dv_side)
   );

   dwsc_drive u_drive (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (dv_valid),
      .in_ready       (dv_ready),
      .quotient       (dv_quotient),
      .side           (dv_side),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .left_fwd_duty  (lf),
      .left_rev_duty  (lr),
      .right_fwd_duty (rf),
      .right_rev_duty (rr)
   );

   assign rsp_tdata = {rr, rf, lr, lf};

`ifndef SYNTHESIS
   a_left_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lf == '0) || (lr == '0))
      else $error("left motor driven in both directions");

   a_right_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rf == '0) || (rr == '0))
      else $error("right motor driven in both directions");

   a_duty_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lf <= cfg.limit) && (lr <= cfg.limit)
                     && (rf <= cfg.limit) && (rr <= cfg.limit))
      else $error("duty above clamp limit");
`endif

endmodule

// ----- rtl/dwsc_csr.sv -----
// Configuration registers and the derived divisor and duty limit.
module dwsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  dwsc_pkg::csr_index_type            csr_index,
   input  logic [dwsc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dwsc_pkg::cfg_type                  cfg
);
   import dwsc_pkg::*;

   logic [BASE_SPEED_W-1:0] base_speed_ff, base_speed_in;
   logic [DIFFER_W-1:0]     differ_ff, differ_in;
   logic [KP_W-1:0]         kp_ff, kp_in;
   logic [DUTY_W-1:0]       max_duty_ff, max_duty_in;

   assign csr_ready = 1'b1;

   always_comb begin
      base_speed_in = base_speed_ff;
      differ_in     = differ_ff;
      kp_in         = kp_ff;
      max_duty_in   = max_duty_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_SPEED: base_speed_in = csr_wdata[BASE_SPEED_W-1:0];
            CSR_DIFFER:     differ_in     = csr_wdata[DIFFER_W-1:0];
            CSR_KP:         kp_in         = csr_wdata[KP_W-1:0];
            CSR_MAX_DUTY:   max_duty_in   = csr_wdata[DUTY_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff <= BASE_SPEED_W'(5120);
         differ_ff     <= DIFFER_W'(240);
         kp_ff         <= KP_W'(40);
         max_duty_ff   <= DUTY_W'(800);
      end else begin
         base_speed_ff <= base_speed_in;
         differ_ff     <= differ_in;
         kp_ff         <= kp_in;
         max_duty_ff   <= max_duty_in;
      end
   end

   always_comb begin
      cfg.base_speed = base_speed_ff;
      cfg.div        = {1'b0, differ_ff, 3'b000} + {3'b000, differ_ff, 1'b0};
      cfg.kp         = kp_ff;
      if ({7'd0, max_duty_ff} > 17'(DUTY_FULL_SCALE)) begin
         cfg.limit = DUTY_W'(DUTY_FULL_SCALE);
      end else begin
         cfg.limit = max_duty_ff;
      end
   end

endmodule

// ----- rtl/dwsc_front.sv -----
// Front stages: magnitudes, encoder scaling with rounding, and the divider operand.
module dwsc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  dwsc_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [dwsc_pkg::DEV_W-1:0]        steer_deviation,
   input  logic [dwsc_pkg::PULSE_W-1:0]      left_pulses,
   input  logic [dwsc_pkg::PULSE_W-1:0]      right_pulses,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [dwsc_pkg::DVD_W-1:0]        dividend,
   output dwsc_pkg::side_type                side
);
   import dwsc_pkg::*;

   localparam int NSTG = 3;

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] rdy;

   logic             f1_neg_ff;
   logic [MAG_W-1:0] f1_mag_ff, f1_mag_in;
   logic             f1_pneg_ff [LANES];
   logic [MAG_W-1:0] f1_pabs_ff [LANES];
   logic [MAG_W-1:0] f1_pabs_in [LANES];
   logic [PULSE_W-1:0] pulses [LANES];

   logic                          f2_neg_ff, f2_mag_zero_ff, f2_inner_zero_ff, f2_inner_zero_in;
   logic [BASE_SPEED_W+MAG_W-1:0] f2_bm_in;
   logic [DVD_W-1:0]              f2_dvd_ff;
   logic                          f2_pneg_ff [LANES];
   logic [PROD_W-1:0]             f2_prod_ff [LANES];

   logic [PROD_W:0]   f3_sum [LANES];
   logic [SPEED_W-1:0] f3_rmag [LANES];
   side_type           f3_side_ff, f3_side_in;
   logic [DVD_W-1:0]   f3_dvd_ff;

   assign rdy[2]   = !v_ff[2] || out_ready;
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   assign pulses[0] = left_pulses;
   assign pulses[1] = right_pulses;

   always_comb begin
      f1_mag_in = steer_deviation[DEV_W-1] ? MAG_W'(-$signed({1'b1, steer_deviation}))
                                           : {1'b0, steer_deviation};
      for (int i = 0; i < LANES; i++) begin
         f1_pabs_in[i] = pulses[i][PULSE_W-1] ? MAG_W'(-$signed({1'b1, pulses[i]}))
                                              : {1'b0, pulses[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         f1_neg_ff <= steer_deviation[DEV_W-1];
         f1_mag_ff <= f1_mag_in;
         for (int i = 0; i < LANES; i++) begin
            f1_pneg_ff[i] <= pulses[i][PULSE_W-1];
            f1_pabs_ff[i] <= f1_pabs_in[i];
         end
      end
   end

   assign f2_bm_in         = cfg.base_speed * f1_mag_ff;
   assign f2_inner_zero_in = (cfg.div == '0) || (f1_mag_ff >= {1'b0, cfg.div});

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         f2_neg_ff        <= f1_neg_ff;
         f2_mag_zero_ff   <= (f1_mag_ff == '0);
         f2_inner_zero_ff <= f2_inner_zero_in;
         f2_dvd_ff        <= f2_bm_in[DVD_W-1:0];
         for (int i = 0; i < LANES; i++) begin
            f2_pneg_ff[i] <= f1_pneg_ff[i];
            f2_prod_ff[i] <= f1_pabs_ff[i] * PULSE_SCALE;
         end
      end
   end

   always_comb begin
      f3_side_in.dev_neg    = f2_neg_ff;
      f3_side_in.mag_zero   = f2_mag_zero_ff;
      f3_side_in.inner_zero = f2_inner_zero_ff;
      for (int i = 0; i < LANES; i++) begin
         f3_sum[i]  = {1'b0, f2_prod_ff[i]} + (PROD_W+1)'(128);
         f3_rmag[i] = f3_sum[i][SPEED_W+7:8];
         f3_side_in.speed[i] = f2_pneg_ff[i] ? -f3_rmag[i] : f3_rmag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         f3_side_ff <= f3_side_in;
         f3_dvd_ff  <= f2_dvd_ff;
      end
   end

   assign out_valid = v_ff[2];
   assign dividend  = f3_dvd_ff;
   assign side      = f3_side_ff;

endmodule

// ----- rtl/dwsc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, side data carried along.
module dwsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dwsc_pkg::DIV_W-1:0]        divisor,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [dwsc_pkg::DVD_W-1:0]        dividend,
   input  dwsc_pkg::side_type                side_in,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [dwsc_pkg::QUO_W-1:0]        quotient,
   output dwsc_pkg::side_type                side_out
);
   import dwsc_pkg::*;

   logic [QUO_W-1:0] v_ff;
   logic [QUO_W-1:0] rdy;
   logic [DIV_W-1:0] rem_ff  [QUO_W];
   logic [QUO_W-1:0] w_ff    [QUO_W];
   side_type         side_ff [QUO_W];

   logic             pv    [QUO_W];
   logic [DIV_W-1:0] prem  [QUO_W];
   logic [QUO_W-1:0] pw    [QUO_W];
   side_type         pside [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DIV_W:0]   trial;
      logic             take;
      logic [DIV_W-1:0] rem_in;
      logic [QUO_W-1:0] w_in;

      if (k == 0) begin : g_first
         assign pv[k]    = in_valid;
         assign prem[k]  = dividend[DVD_W-1:QUO_W];
         assign pw[k]    = dividend[QUO_W-1:0];
         assign pside[k] = side_in;
      end else begin : g_next
         assign pv[k]    = v_ff[k-1];
         assign prem[k]  = rem_ff[k-1];
         assign pw[k]    = w_ff[k-1];
         assign pside[k] = side_ff[k-1];
      end

      if (k == QUO_W - 1) begin : g_last
         assign rdy[k] = !v_ff[k] || out_ready;
      end else begin : g_mid
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end

      assign trial  = {prem[k], pw[k][QUO_W-1]};
      assign take   = trial >= {1'b0, divisor};
      assign rem_in = take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      assign w_in   = {pw[k][QUO_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= pv[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            w_ff[k]    <= w_in;
            side_ff[k] <= pside[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QUO_W-1];
   assign quotient  = w_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

// ----- rtl/dwsc_drive.sv -----
// Drive stages: wheel targets, feedforward plus proportional drive, clamp and duty split.
module dwsc_drive (
   input  logic                              clock,
   input  logic                              reset,
   input  dwsc_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [dwsc_pkg::QUO_W-1:0]        quotient,
   input  dwsc_pkg::side_type                side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [dwsc_pkg::DUTY_W-1:0]       left_fwd_duty,
   output logic [dwsc_pkg::DUTY_W-1:0]       left_rev_duty,
   output logic [dwsc_pkg::DUTY_W-1:0]       right_fwd_duty,
   output logic [dwsc_pkg::DUTY_W-1:0]       right_rev_duty
);
   import dwsc_pkg::*;

   localparam int NSTG = 5;

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] rdy;

   logic [BASE_SPEED_W-1:0]  inner_in;
   logic [BASE_SPEED_W-1:0]  tgt_in [LANES];
   logic [BASE_SPEED_W-1:0]  tgt_ff [LANES];
   logic signed [ERR_W-1:0]  err_in [LANES];
   logic signed [ERR_W-1:0]  err_ff [LANES];
   logic [TG_W-1:0]          tg_ff  [LANES];
   logic signed [PE_W-1:0]   pe_ff  [LANES];
   logic [ACC_W-1:0]         acc_in [LANES];
   logic [ACC_W-1:0]         acc_ff [LANES];
   logic signed [DRV_W-1:0]  d_in   [LANES];
   logic signed [DRV_W-1:0]  d_ff   [LANES];
   logic signed [DRV_W-1:0]  lim;
   logic signed [DRV_W-1:0]  c      [LANES];
   logic signed [DRV_W-1:0]  nc     [LANES];
   logic [DUTY_W-1:0]        fwd_in [LANES];
   logic [DUTY_W-1:0]        rev_in [LANES];
   logic [DUTY_W-1:0]        fwd_ff [LANES];
   logic [DUTY_W-1:0]        rev_ff [LANES];
   logic [GAIN_W-1:0]        gain   [LANES];
   logic [OFS_W-1:0]         ofs    [LANES];

   assign gain[0] = FF_GAIN_L;
   assign gain[1] = FF_GAIN_R;
   assign ofs[0]  = FF_OFS_L;
   assign ofs[1]  = FF_OFS_R;

   assign rdy[4]   = !v_ff[4] || out_ready;
   assign rdy[3]   = !v_ff[3] || rdy[4];
   assign rdy[2]   = !v_ff[2] || rdy[3];
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < NSTG; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_comb begin
      priority if (side.mag_zero) begin
         inner_in = cfg.base_speed;
      end else if (side.inner_zero) begin
         inner_in = '0;
      end else begin
         inner_in = cfg.base_speed - quotient;
      end
      tgt_in[0] = side.dev_neg ? inner_in : cfg.base_speed;
      tgt_in[1] = side.dev_neg ? cfg.base_speed : inner_in;
      for (int i = 0; i < LANES; i++) begin
         err_in[i] = $signed({{(ERR_W-BASE_SPEED_W){1'b0}}, tgt_in[i]})
                   - $signed({{(ERR_W-SPEED_W){side.speed[i][SPEED_W-1]}}, side.speed[i]});
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         acc_in[i] = {{(ACC_W-TG_W){1'b0}}, tg_ff[i]}
                   + {{(ACC_W-OFS_W-8){1'b0}}, ofs[i], 8'd0}
                   + {pe_ff[i][PE_W-1], pe_ff[i], 16'd0};
         d_in[i]   = $signed(acc_ff[i][ACC_W-1:FRAC_W])
                   + DRV_W'(acc_ff[i][ACC_W-1] && (acc_ff[i][FRAC_W-1:0] != '0));
      end
   end

   assign lim = $signed({{(DRV_W-DUTY_W){1'b0}}, cfg.limit});

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         priority if (d_ff[i] > lim) begin
            c[i] = lim;
         end else if (d_ff[i] < -lim) begin
            c[i] = -lim;
         end else begin
            c[i] = d_ff[i];
         end
         nc[i] = -c[i];
         if (c[i] > 0) begin
            fwd_in[i] = c[i][DUTY_W-1:0];
            rev_in[i] = '0;
         end else begin
            fwd_in[i] = '0;
            rev_in[i] = nc[i][DUTY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (rdy[0]) begin
            tgt_ff[i] <= tgt_in[i];
            err_ff[i] <= err_in[i];
         end
         if (rdy[1]) begin
            tg_ff[i] <= tgt_ff[i] * gain[i];
            pe_ff[i] <= $signed({1'b0, cfg.kp}) * err_ff[i];
         end
         if (rdy[2]) acc_ff[i] <= acc_in[i];
         if (rdy[3]) d_ff[i] <= d_in[i];
         if (rdy[4]) begin
            fwd_ff[i] <= fwd_in[i];
            rev_ff[i] <= rev_in[i];
         end
      end
   end

   assign out_valid      = v_ff[4];
   assign left_fwd_duty  = fwd_ff[0];
   assign left_rev_duty  = rev_ff[0];
   assign right_fwd_duty = fwd_ff[1];
   assign right_rev_duty = rev_ff[1];

`ifndef SYNTHESIS
   a_target_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (tgt_ff[0] <= cfg.base_speed) && (tgt_ff[1] <= cfg.base_speed)
                  && ((tgt_ff[0] == cfg.base_speed) || (tgt_ff[1] == cfg.base_speed)))
      else $error("wheel target above base speed or no outer wheel at base speed");
`endif

endmodule
